### design/awp_pkg.sv
// ----------------------------------------------------------------------------
// awp_pkg
// Types and constants shared by the auto-scaled waveform plotter.
// ----------------------------------------------------------------------------
package awp_pkg;

  localparam int unsigned RING_DEPTH_DEF = 64;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned NUM_W    = 23;  // scale (7 bit) times sample difference
  localparam int unsigned QUOT_W   = 7;   // row never exceeds height - 1
  localparam int unsigned STEP_W   = 3;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = 16'hFFFF;
  localparam logic [SAMPLE_W-1:0] MIN_SPAN_RST = 16'd100;
  localparam logic [6:0]          PLOT_LEFT_RST = 7'd0;

  // opcodes
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic REG_MIN_SPAN  = 1'b0;
  localparam logic REG_PLOT_LEFT = 1'b1;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [SAMPLE_W-1:0] sample;
    logic [5:0]          plot_top;
    logic [6:0]          plot_height;
  } cmd_t;

  typedef struct packed {
    logic [7:0] point_x;
    logic [6:0] point_y;
    logic [7:0] from_x;
    logic [6:0] from_y;
    logic       connect;
    logic       last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_WIDEN,
    ST_PT_RD,
    ST_PT_MUL,
    ST_PT_DIV,
    ST_PT_EMIT
  } state_e;

endpackage

### design/autoscaled_waveform_plotter.sv
// ----------------------------------------------------------------------------
// autoscaled_waveform_plotter
// Sample ring with auto-scaled plotting: one shared compare-subtract unit
// turns each stored sample into a screen point, one bit of the row per cycle.
// ----------------------------------------------------------------------------
// push and clear leave busy low
// a draw keeps busy high through the min/max scan (a read and a compare per
//   sample), one step to widen the band, then per point a ram read, multiply,
//   seven divide steps and emit on the shared divider
// each point appears on res_o for one cycle, in the cycle after its emit step
// reset empties the ring and loads min_span 100, plot_left 0; ring data undefined
module autoscaled_waveform_plotter #(
  parameter int unsigned RING_DEPTH = awp_pkg::RING_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  awp_pkg::cmd_t cmd_i,
  input  logic          cfg_we_i,
  input  logic          cfg_addr_i,
  input  logic [15:0]   cfg_wdata_i,
  output logic          res_valid_o,
  output awp_pkg::res_t res_o
);

  localparam int unsigned PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned SW = awp_pkg::SAMPLE_W;
  localparam int unsigned NW = awp_pkg::NUM_W;
  localparam int unsigned QW = awp_pkg::QUOT_W;
  localparam int unsigned KW = awp_pkg::STEP_W;

  // configuration
  logic [SW-1:0] min_span_q;
  logic [6:0]    plot_left_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_span_q  <= awp_pkg::MIN_SPAN_RST;
      plot_left_q <= awp_pkg::PLOT_LEFT_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        awp_pkg::REG_MIN_SPAN:  min_span_q  <= cfg_wdata_i;
        awp_pkg::REG_PLOT_LEFT: plot_left_q <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  awp_pkg::state_e state_q, state_d;

  logic [PW-1:0] wp_q, wp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW-1:0] start_q, start_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [SW-1:0] lo_q, lo_d, hi_q, hi_d, span_q, span_d;
  logic [5:0]    top_q, top_d;
  logic [QW-1:0] scale_q, scale_d;
  logic [NW-1:0] num_q, num_d;
  logic [QW-1:0] quot_q, quot_d;
  logic [KW-1:0] k_q, k_d;
  logic [7:0]    x_q, x_d, px_q, px_d;
  logic [6:0]    py_q, py_d;
  logic          res_valid_q, res_valid_d;
  awp_pkg::res_t res_q, res_d;

  logic          ram_we;
  logic [SW-1:0] ram_rdata;

  awp_ram #(
    .WIDTH (SW),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (cmd_i.sample),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  logic          accept;
  logic [CW:0]   start_sum;
  logic [PW-1:0] start_calc;
  logic [PW-1:0] rd_ptr_inc;
  logic [CW-1:0] idx_inc;
  logic          idx_last;
  logic [SW-1:0] ms;
  logic [SW-1:0] raw_span;
  logic [SW:0]   mid_sum;
  logic [SW-1:0] mid, half, nlo;
  logic [SW:0]   nhi_sum;
  logic [SW-1:0] v_clamp, diff;
  logic [NW-1:0] trial;
  logic [6:0]    y_calc;

  assign accept = start && !busy;
  assign busy   = (state_q != awp_pkg::ST_IDLE);
  assign ram_we = accept && (cmd_i.opcode == awp_pkg::OP_PUSH);

  // oldest entry: (wp + depth - count) mod depth, sum stays below twice the depth
  assign start_sum  = (CW+1)'(wp_q) + (CW+1)'(RING_DEPTH) - (CW+1)'(cnt_q);
  assign start_calc = (start_sum >= (CW+1)'(RING_DEPTH)) ?
                      PW'(start_sum - (CW+1)'(RING_DEPTH)) : PW'(start_sum);

  assign rd_ptr_inc = (rd_ptr_q == PW'(RING_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
  assign idx_inc    = idx_q + CW'(1);
  assign idx_last   = (idx_inc == cnt_q);

  // band widening
  assign ms       = (min_span_q == '0) ? SW'(1) : min_span_q;
  assign raw_span = hi_q - lo_q;
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = mid_sum[SW:1];
  assign half     = {1'b0, ms[SW-1:1]};
  assign nlo      = (mid > half) ? (mid - half) : '0;
  assign nhi_sum  = {1'b0, nlo} + {1'b0, ms};

  assign v_clamp = (ram_rdata < lo_q) ? lo_q : ((ram_rdata > hi_q) ? hi_q : ram_rdata);
  assign diff    = hi_q - v_clamp;

  // shared compare-subtract unit of the row divider
  assign trial  = NW'(span_q) << k_q;
  assign y_calc = 7'({1'b0, top_q}) + quot_q;

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    cnt_d       = cnt_q;
    rd_ptr_d    = rd_ptr_q;
    start_d     = start_q;
    idx_d       = idx_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    span_d      = span_q;
    top_d       = top_q;
    scale_d     = scale_q;
    num_d       = num_q;
    quot_d      = quot_q;
    k_d         = k_q;
    x_d         = x_q;
    px_d        = px_q;
    py_d        = py_q;
    res_valid_d = 1'b0;
    res_d       = res_q;

    case (state_q)
      awp_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd_i.opcode)
            awp_pkg::OP_PUSH: begin
              wp_d = (wp_q == PW'(RING_DEPTH - 1)) ? '0 : wp_q + PW'(1);
              if (cnt_q != CW'(RING_DEPTH)) begin
                cnt_d = cnt_q + CW'(1);
              end
            end
            awp_pkg::OP_CLEAR: begin
              wp_d  = '0;
              cnt_d = '0;
            end
            awp_pkg::OP_DRAW: begin
              if (cnt_q != '0) begin
                rd_ptr_d = start_calc;
                start_d  = start_calc;
                idx_d    = '0;
                lo_d     = awp_pkg::SAMPLE_MAX;
                hi_d     = '0;
                top_d    = cmd_i.plot_top;
                scale_d  = (cmd_i.plot_height == '0) ? '0 : cmd_i.plot_height - QW'(1);
                x_d      = 8'(plot_left_q) + 8'(RING_DEPTH) - 8'(cnt_q);
                state_d  = awp_pkg::ST_SCAN_RD;
              end
            end
            default: ;
          endcase
        end
      end
      awp_pkg::ST_SCAN_RD: begin
        state_d = awp_pkg::ST_SCAN_CMP;
      end
      awp_pkg::ST_SCAN_CMP: begin
        if (ram_rdata < lo_q) lo_d = ram_rdata;
        if (ram_rdata > hi_q) hi_d = ram_rdata;
        if (idx_last) begin
          rd_ptr_d = start_q;
          idx_d    = '0;
          state_d  = awp_pkg::ST_WIDEN;
        end else begin
          rd_ptr_d = rd_ptr_inc;
          idx_d    = idx_inc;
          state_d  = awp_pkg::ST_SCAN_RD;
        end
      end
      awp_pkg::ST_WIDEN: begin
        if (raw_span < ms) begin
          lo_d   = nlo;
          hi_d   = nhi_sum[SW] ? awp_pkg::SAMPLE_MAX : nhi_sum[SW-1:0];
          span_d = ms;
        end else begin
          span_d = raw_span;
        end
        state_d = awp_pkg::ST_PT_RD;
      end
      awp_pkg::ST_PT_RD: begin
        state_d = awp_pkg::ST_PT_MUL;
      end
      awp_pkg::ST_PT_MUL: begin
        num_d   = NW'(scale_q) * NW'(diff);
        quot_d  = '0;
        k_d     = KW'(QW - 1);
        state_d = awp_pkg::ST_PT_DIV;
      end
      awp_pkg::ST_PT_DIV: begin
        if (num_q >= trial) begin
          num_d       = num_q - trial;
          quot_d[k_q] = 1'b1;
        end
        if (k_q == '0) begin
          state_d = awp_pkg::ST_PT_EMIT;
        end else begin
          k_d = k_q - KW'(1);
        end
      end
      awp_pkg::ST_PT_EMIT: begin
        res_valid_d   = 1'b1;
        res_d.point_x = x_q;
        res_d.point_y = y_calc;
        res_d.from_x  = (idx_q == '0) ? '0 : px_q;
        res_d.from_y  = (idx_q == '0) ? '0 : py_q;
        res_d.connect = (idx_q != '0);
        res_d.last    = idx_last;
        px_d          = x_q;
        py_d          = y_calc;
        x_d           = x_q + 8'd1;
        rd_ptr_d      = rd_ptr_inc;
        idx_d         = idx_inc;
        state_d       = idx_last ? awp_pkg::ST_IDLE : awp_pkg::ST_PT_RD;
      end
      default: begin
        state_d = awp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= awp_pkg::ST_IDLE;
      wp_q        <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q <= rd_ptr_d;
    start_q  <= start_d;
    idx_q    <= idx_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    span_q   <= span_d;
    top_q    <= top_d;
    scale_q  <= scale_d;
    num_q    <= num_d;
    quot_q   <= quot_d;
    k_q      <= k_d;
    x_q      <= x_d;
    px_q     <= px_d;
    py_q     <= py_d;
    res_q    <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(RING_DEPTH))
    else $error("sample count beyond ring depth");

  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= PW'(RING_DEPTH - 1))
    else $error("write pointer beyond ring depth");

  a_res_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(state_q == awp_pkg::ST_PT_EMIT))
    else $error("item strobe without emit step");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == awp_pkg::ST_PT_EMIT) |-> (quot_q <= scale_q))
    else $error("row exceeds plot height");

  a_band_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == awp_pkg::ST_PT_MUL) |-> (lo_q <= hi_q))
    else $error("band bounds out of order");
`endif

endmodule

### design/awp_ram.sv
// ----------------------------------------------------------------------------
// awp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module awp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### tb/sv/autoscaled_waveform_plotter_test.sv
// ----------------------------------------------------------------------------
// autoscaled_waveform_plotter_test
// Self-checking bench for the waveform plotter: pushes, clears and draws are
// sent with bursty timing, and a local copy of the sample ring works out the
// auto-scaled points that every draw must produce, in order, field by field.
// ----------------------------------------------------------------------------
module autoscaled_waveform_plotter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = awp_pkg::RING_DEPTH_DEF;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam logic [1:0]  OP_NOP      = 2'd3;   // unused opcode, block ignores it

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          start;
  logic          busy;
  awp_pkg::cmd_t cmd_i;
  logic          cfg_we_i;
  logic          cfg_addr_i;
  logic [15:0]   cfg_wdata_i;
  logic          res_valid_o;
  awp_pkg::res_t res_o;

  // local copy of the block's state and registers
  logic [15:0] ring_copy [DEPTH];
  int unsigned ring_wr;
  int unsigned ring_count;
  int unsigned span_min;
  int unsigned left_col;

  awp_pkg::res_t pending_points [$];
  awp_pkg::res_t want_point;
  int          error_count = 0;
  int          burst_left  = 0;
  int          quiet_cycles = 0;

  autoscaled_waveform_plotter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always #5 clk_i = ~clk_i;

  // updates the local ring and queues the points a draw must produce
  function automatic void plot_points(awp_pkg::cmd_t c);
    int unsigned oldest, lo, hi, band, ms, mid, half, scale, v, row, x, y, px, py;
    awp_pkg::res_t p;
    case (c.opcode)
      awp_pkg::OP_PUSH: begin
        ring_copy[ring_wr] = c.sample;
        ring_wr = (ring_wr + 1) % DEPTH;
        if (ring_count < DEPTH) ring_count++;
      end
      awp_pkg::OP_CLEAR: begin
        ring_wr = 0;
        ring_count = 0;
      end
      awp_pkg::OP_DRAW: begin
        if (ring_count != 0) begin
          oldest = (ring_wr + DEPTH - ring_count) % DEPTH;
          lo = 32'hFFFF;
          hi = 0;
          for (int i = 0; i < ring_count; i++) begin
            v = ring_copy[(oldest + i) % DEPTH];
            if (v < lo) lo = v;
            if (v > hi) hi = v;
          end
          ms = (span_min == 0) ? 1 : span_min;
          band = hi - lo;
          // widen a narrow band around its midpoint, kept inside 0..0xFFFF
          if (band < ms) begin
            mid  = (lo + hi) / 2;
            half = ms / 2;
            lo   = (mid > half) ? mid - half : 0;
            hi   = lo + ms;
            if (hi > awp_pkg::SAMPLE_MAX) hi = awp_pkg::SAMPLE_MAX;
            band = ms;
          end
          scale = (c.plot_height == 0) ? 0 : c.plot_height - 1;
          px = 0;
          py = 0;
          for (int i = 0; i < ring_count; i++) begin
            v = ring_copy[(oldest + i) % DEPTH];
            if (v < lo) v = lo;
            else if (v > hi) v = hi;
            row = (scale * (hi - v)) / band;
            x = (left_col + DEPTH - ring_count + i) & 32'hFF;
            y = (c.plot_top + row) & 32'h7F;
            p.point_x = x[7:0];
            p.point_y = y[6:0];
            p.from_x  = (i > 0) ? px[7:0] : 8'd0;
            p.from_y  = (i > 0) ? py[6:0] : 7'd0;
            p.connect = (i > 0);
            p.last    = (i + 1 == ring_count);
            pending_points.push_back(p);
            px = x;
            py = y;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic awp_pkg::cmd_t make_cmd(logic [1:0] op, logic [15:0] smp,
                                             logic [5:0] top, logic [6:0] height);
    awp_pkg::cmd_t c;
    c.opcode      = op;
    c.sample      = smp;
    c.plot_top    = top;
    c.plot_height = height;
    return c;
  endfunction

  function automatic logic [15:0] make_sample(int mode, logic [15:0] base);
    case (mode)
      0:       return 16'($urandom_range(0, 16'hFFFF));
      1:       return base + 16'($urandom_range(0, 150));
      2:       return 16'hFFFF - 16'($urandom_range(0, 80));
      default: return 16'($urandom_range(0, 80));
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      error_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // one item: holds start until the block takes it
  task automatic send_cmd(awp_pkg::cmd_t c);
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    plot_points(c);
  endtask

  // sender works in bursts with random gaps in between
  task automatic issue_cmd(awp_pkg::cmd_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    send_cmd(c);
  endtask

  task automatic push(logic [15:0] smp);
    issue_cmd(make_cmd(awp_pkg::OP_PUSH, smp, 6'($urandom), 7'($urandom)));
  endtask

  task automatic draw(logic [5:0] top, logic [6:0] height);
    issue_cmd(make_cmd(awp_pkg::OP_DRAW, 16'($urandom), top, height));
  endtask

  task automatic clear_ring();
    issue_cmd(make_cmd(awp_pkg::OP_CLEAR, 16'($urandom), 6'($urandom), 7'($urandom)));
  endtask

  // wait until every point is in and the block has gone quiet
  task automatic settle();
    start <= 1'b0;
    while (pending_points.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(logic [15:0] span, logic [6:0] left);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= awp_pkg::REG_MIN_SPAN;
    cfg_wdata_i <= span;
    @(posedge clk_i);
    cfg_addr_i  <= awp_pkg::REG_PLOT_LEFT;
    cfg_wdata_i <= {9'd0, left};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    span_min = span;
    left_col = left;
  endtask

  task automatic test_empty_and_full_range();
    draw(6'd0, 7'd64);
    issue_cmd(make_cmd(OP_NOP, 16'hFFFF, 6'd63, 7'd127));
    push(16'h0000);
    push(16'hFFFF);
    draw(6'd0, 7'd64);
  endtask

  task automatic test_band_edges();
    // narrow band at the top: upper bound held at 0xFFFF
    clear_ring();
    push(16'd65530);
    push(16'hFFFF);
    draw(6'd63, 7'd127);
    // narrow band near zero: lower bound floored
    clear_ring();
    push(16'd3);
    push(16'd5);
    draw(6'd5, 7'd0);
    draw(6'd20, 7'd64);
  endtask

  task automatic test_config_extremes();
    settle();
    set_config(16'd0, 7'd127);
    push(16'd7);
    push(16'd7);
    draw(6'd0, 7'd64);
    settle();
    set_config(16'hFFFF, 7'd0);
    draw(6'd1, 7'd33);
    settle();
    set_config(16'd1, 7'd64);
    draw(6'd2, 7'd1);
  endtask

  task automatic test_ring_wrap();
    int n;
    int mode;
    logic [15:0] base;
    settle();
    set_config(16'($urandom_range(1, 2000)), 7'($urandom));
    clear_ring();
    n = DEPTH + $urandom_range(1, 6);
    mode = $urandom_range(0, 3);
    base = 16'($urandom);
    repeat (n) push(make_sample(mode, base));
    draw(6'($urandom), 7'($urandom_range(1, 64)));
    repeat (3) push(make_sample(mode, base));
    draw(6'($urandom), 7'($urandom_range(0, 127)));
  endtask

  task automatic test_random_traffic();
    int sent;
    int n;
    int mode;
    int pick;
    logic [15:0] base;
    logic [15:0] span;
    logic [6:0]  left;
    sent = 0;
    while (sent < 16) begin
      if ($urandom_range(0, 3) == 0) begin
        settle();
        case ($urandom_range(0, 5))
          0:       span = 16'd0;
          1:       span = 16'd1;
          2:       span = 16'hFFFF;
          3:       span = awp_pkg::MIN_SPAN_RST;
          4:       span = 16'($urandom_range(1, 400));
          default: span = 16'($urandom_range(1, 16'hFFFF));
        endcase
        case ($urandom_range(0, 2))
          0:       left = 7'd0;
          1:       left = 7'd127;
          default: left = 7'($urandom);
        endcase
        set_config(span, left);
      end
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        issue_cmd(make_cmd(OP_NOP, 16'($urandom), 6'($urandom), 7'($urandom)));
      end else if (pick == 1) begin
        clear_ring();
        sent++;
      end else begin
        n = $urandom_range(1, 8);
        mode = $urandom_range(0, 3);
        base = 16'($urandom);
        repeat (n) push(make_sample(mode, base));
        draw(6'($urandom), ($urandom_range(0, 7) == 0) ? 7'($urandom) :
                           7'($urandom_range(1, 64)));
        sent += n + 1;
        if ($urandom_range(0, 4) == 0) begin
          draw(6'($urandom), 7'($urandom_range(1, 64)));
          sent++;
        end
      end
    end
  endtask

  // every strobed point is compared with the oldest one still expected
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (pending_points.size() == 0) begin
        error_count++;
        $error("point with nothing expected: x %0d y %0d", res_o.point_x, res_o.point_y);
      end else begin
        want_point = pending_points.pop_front();
        check_field("point_x", want_point.point_x, res_o.point_x);
        check_field("point_y", want_point.point_y, res_o.point_y);
        check_field("from_x",  want_point.from_x,  res_o.from_x);
        check_field("from_y",  want_point.from_y,  res_o.from_y);
        check_field("connect", want_point.connect, res_o.connect);
        check_field("last",    want_point.last,    res_o.last);
      end
    end
  end

  // watchdog: cycles in which neither an item nor a point moves
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid_o) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    cmd_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_addr_i  = awp_pkg::REG_MIN_SPAN;
    cfg_wdata_i = '0;
    ring_wr     = 0;
    ring_count  = 0;
    span_min    = awp_pkg::MIN_SPAN_RST;
    left_col    = awp_pkg::PLOT_LEFT_RST;
    foreach (ring_copy[i]) ring_copy[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_full_range();
    test_band_edges();
    test_config_extremes();
    test_ring_wrap();
    test_random_traffic();

    settle();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
